>>> src/gdrc_pkg.sv
// Shared types and constants of the grid DDA ray caster.
package gdrc_pkg;

   // Fixed point and geometry
   localparam int FracBits     = 16;
   localparam int MapBits      = 6;
   localparam int MapAddrBits  = 2 * MapBits;
   localparam int MapCells     = 1 << MapAddrBits;
   localparam int ScreenWidth  = 640;
   localparam int ScreenHeight = 480;
   localparam int WalkLimit    = 2 * (1 << MapBits) + 4;

   // Field and datapath widths
   localparam int CodeBits   = 8;
   localparam int ColBits    = 10;
   localparam int PosBits    = 22;
   localparam int VecBits    = 18;
   localparam int CamBits    = 19;
   localparam int RayBits    = 21;
   localparam int DeltaBits  = 33;
   localparam int SideBits   = 42;
   localparam int CoordBits  = 8;
   localparam int PerpBits   = 24;
   localparam int LineBits   = 12;
   localparam int RowBits    = 9;
   localparam int IterBits   = 8;
   localparam int DivNumBits = 42;
   localparam int DivDenBits = 24;
   localparam int DivSteps   = DivNumBits / 2;
   localparam int DivCntBits = 5;

   // Camera offset 2*col*ONE/ScreenWidth = col*1024/5, done as col*ceil(2^22/5) >> 12;
   // exact for every 10-bit column
   localparam int                      CamRecipBits = 20;
   localparam int                      CamShift     = 12;
   localparam logic [CamRecipBits-1:0] CamRecip     = 20'd838861;

   localparam logic [PerpBits-1:0]   PerpMax    = '1;
   localparam logic [LineBits-1:0]   LineMax    = '1;
   localparam logic [RowBits-1:0]    HalfHeight = RowBits'(ScreenHeight / 2);
   localparam logic [RowBits-1:0]    LastRow    = RowBits'(ScreenHeight - 1);
   localparam logic [DivNumBits-1:0] DeltaNum   = DivNumBits'(64'd1 << (2 * FracBits));
   localparam logic [DivNumBits-1:0] LineNum    = DivNumBits'(ScreenHeight * (1 << FracBits));

   // Register indexes
   localparam int CsrBits = 3;
   localparam logic [CsrBits-1:0] CsrPosX   = 3'd0;
   localparam logic [CsrBits-1:0] CsrPosY   = 3'd1;
   localparam logic [CsrBits-1:0] CsrDirX   = 3'd2;
   localparam logic [CsrBits-1:0] CsrDirY   = 3'd3;
   localparam logic [CsrBits-1:0] CsrPlaneX = 3'd4;
   localparam logic [CsrBits-1:0] CsrPlaneY = 3'd5;

   // Request kinds
   localparam logic ActWrite = 1'b0;
   localparam logic ActCast  = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [MapBits-1:0]   cell_x;
      logic [MapBits-1:0]   cell_y;
      logic [CodeBits-1:0]  cell_code;
      logic [ColBits-1:0]   column;
   } req_type;

   typedef struct packed {
      logic    valid;
      logic    cast;
      req_type req;
   } head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef struct packed {
      logic [PosBits-1:0] pos_x;
      logic [PosBits-1:0] pos_y;
      logic [VecBits-1:0] dir_x;
      logic [VecBits-1:0] dir_y;
      logic [VecBits-1:0] plane_x;
      logic [VecBits-1:0] plane_y;
   } cfg_type;

   typedef struct packed {
      logic [ColBits-1:0]  out_column;
      logic [MapBits-1:0]  hit_x;
      logic [MapBits-1:0]  hit_y;
      logic [CodeBits-1:0] wall_code;
      logic                hit_side;
      logic                escaped;
      logic [PerpBits-1:0] perp_distance;
      logic [LineBits-1:0] line_height;
      logic [RowBits-1:0]  draw_start;
      logic [RowBits-1:0]  draw_end;
   } rsp_type;

endpackage

>>> src/gdrc_front.sv
// Front end: request intake, classification and a two-entry request queue.
module gdrc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gdrc_pkg::req_type     req_in,
   input  gdrc_pkg::back_ctl_type back_ctl,
   output logic                  busy,
   output gdrc_pkg::head_type    head
);

   gdrc_pkg::req_type q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   // Hold off new requests while the map clears or the queue is full
   assign busy = back_ctl.clearing | (count_ff == 2'd2);
   assign push = start & ~busy;
   assign pop  = back_ctl.pop & (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= req_in;
   end

   // Head of queue, tagged by kind
   assign head.valid = (count_ff != 2'd0);
   assign head.req   = q_ff[rd_ptr_ff];
   assign head.cast  = (q_ff[rd_ptr_ff].action == gdrc_pkg::ActCast);

endmodule

>>> src/gdrc_div.sv
// Shared unsigned divider, restoring, two quotient bits per cycle.
module gdrc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gdrc_pkg::DivNumBits-1:0]   num,
   input  logic [gdrc_pkg::DivDenBits-1:0]   den,
   output logic                              done,
   output logic [gdrc_pkg::DivNumBits-1:0]   quot
);

   localparam int NB = gdrc_pkg::DivNumBits;
   localparam int DB = gdrc_pkg::DivDenBits;

   logic [DB-1:0] rem_ff;
   logic [NB-1:0] q_ff;
   logic [DB-1:0] den_ff;
   logic [gdrc_pkg::DivCntBits-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;
   logic [DB:0]   r1;
   logic [DB:0]   r2;
   logic          b1;
   logic          b2;
   logic [DB-1:0] m1;
   logic [DB-1:0] m2;

   // Two dependent subtract steps
   always_comb begin
      r1 = {rem_ff, q_ff[NB-1]};
      b1 = (r1 >= {1'b0, den_ff});
      m1 = b1 ? DB'(r1 - {1'b0, den_ff}) : r1[DB-1:0];
      r2 = {m1, q_ff[NB-2]};
      b2 = (r2 >= {1'b0, den_ff});
      m2 = b2 ? DB'(r2 - {1'b0, den_ff}) : r2[DB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == gdrc_pkg::DivCntBits'(gdrc_pkg::DivSteps - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= num;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= m2;
         q_ff   <= {q_ff[NB-3:0], b1, b2};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> src/gdrc_back.sv
// Back end: map memory, ray setup, DDA walk and distance/height sequencer.
module gdrc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gdrc_pkg::cfg_type      cfg,
   input  gdrc_pkg::head_type     head,
   output gdrc_pkg::back_ctl_type back_ctl,
   output logic                   rsp_valid,
   output gdrc_pkg::rsp_type      rsp
);

   localparam int FB = gdrc_pkg::FracBits;
   localparam int MB = gdrc_pkg::MapBits;
   localparam int AB = gdrc_pkg::MapAddrBits;
   localparam int CB = gdrc_pkg::CoordBits;
   localparam int RB = gdrc_pkg::RayBits;
   localparam int SB = gdrc_pkg::SideBits;
   localparam int NB = gdrc_pkg::DivNumBits;
   localparam int DB = gdrc_pkg::DivDenBits;
   localparam int PB = gdrc_pkg::PerpBits;
   localparam int LB = gdrc_pkg::LineBits;
   localparam int WB = gdrc_pkg::RowBits;
   localparam int PRB = gdrc_pkg::VecBits + gdrc_pkg::CamBits;
   localparam int FXB = FB + 1;
   localparam int SPB = 2 * FXB;
   localparam int CPB = gdrc_pkg::ColBits + gdrc_pkg::CamRecipBits;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_CAM, S_MULX, S_ADDX, S_ADDY,
      S_DX, S_DX_W, S_DY, S_DY_W, S_SD0, S_SD1, S_SD2, S_SD3, S_SD4,
      S_STEP, S_CHECK, S_PERP, S_PERP_W, S_LH, S_LH_W, S_OUT
   } state_type;

   state_type state_ff;

   // Map memory
   logic [gdrc_pkg::CodeBits-1:0] map_mem [gdrc_pkg::MapCells];
   logic [gdrc_pkg::CodeBits-1:0] mem_q_ff;
   logic                          mem_we;
   logic [AB-1:0]                 mem_waddr;
   logic [gdrc_pkg::CodeBits-1:0] mem_wdata;
   logic [AB-1:0]                 rd_addr;
   logic [AB-1:0]                 clr_cnt_ff;

   // Divider hookup
   logic          div_start_ff;
   logic [NB-1:0] div_num_ff;
   logic [DB-1:0] div_den_ff;
   logic          div_done;
   logic [NB-1:0] div_quot;

   // Cast state
   logic [gdrc_pkg::ColBits-1:0]        column_ff;
   logic signed [gdrc_pkg::CamBits-1:0] cam_ff;
   logic signed [PRB-1:0]               cprod_ff;
   logic [RB-1:0]                       rx_ff;
   logic [RB-1:0]                       ry_ff;
   logic [gdrc_pkg::DeltaBits-1:0]      dx_ff;
   logic [gdrc_pkg::DeltaBits-1:0]      dy_ff;
   logic [SPB-1:0]                      sprod_ff;
   logic [SB-1:0]                       sdx_ff;
   logic [SB-1:0]                       sdy_ff;
   logic [CB-1:0]                       mx_ff;
   logic [CB-1:0]                       my_ff;
   logic                                side_ff;
   logic                                oob_ff;
   logic                                escaped_ff;
   logic [gdrc_pkg::CodeBits-1:0]       code_ff;
   logic [gdrc_pkg::IterBits-1:0]       iter_ff;
   logic [PB-1:0]                       perp_ff;
   logic [LB-1:0]                       lh_ff;
   logic                                rsp_valid_ff;
   gdrc_pkg::rsp_type                   rsp_ff;

   // Combinational helpers
   logic [CPB-1:0]        cam_prod;
   logic                  rx_neg;
   logic                  ry_neg;
   logic [RB-2:0]         rx_abs;
   logic [RB-2:0]         ry_abs;
   logic [FXB-1:0]        frac_x;
   logic [FXB-1:0]        frac_y;
   logic [FXB-1:0]        mul_a;
   logic [FXB-1:0]        mul_b;
   logic [SPB-1:0]        mul_p;
   logic [gdrc_pkg::VecBits-1:0] cam_plane;
   logic signed [PRB-1:0] cam_p;
   logic                  step_x;
   logic [CB-1:0]         nx;
   logic [CB-1:0]         ny;
   logic                  oob_next;
   logic [CB-1:0]         coord;
   logic                  adj;
   logic [CB:0]           bsum;
   logic [25:0]           num_w;
   logic [24:0]           num_abs;
   logic [RB-1:0]         ray_w;
   logic [RB-2:0]         ray_abs;
   logic                  perp_zero;
   logic [gdrc_pkg::PosBits-1:0] pos_w;
   logic [LB-2:0]         half;
   logic [LB-1:0]         de_sum;
   logic [MB-1:0]         hit_x_w;
   logic [MB-1:0]         hit_y_w;

   gdrc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Queue handshake and status
   assign back_ctl.pop      = (state_ff == S_IDLE) & head.valid;
   assign back_ctl.clearing = (state_ff == S_CLEAR);

   // Camera offset by reciprocal multiply
   assign cam_prod = column_ff * gdrc_pkg::CamRecip;

   // Ray signs and magnitudes
   assign rx_neg = rx_ff[RB-1];
   assign ry_neg = ry_ff[RB-1];
   assign rx_abs = rx_neg ? (RB-1)'(-rx_ff) : rx_ff[RB-2:0];
   assign ry_abs = ry_neg ? (RB-1)'(-ry_ff) : ry_ff[RB-2:0];

   // Distance to the next border in the step direction
   assign frac_x = rx_neg ? {1'b0, cfg.pos_x[FB-1:0]}
                          : FXB'(1 << FB) - {1'b0, cfg.pos_x[FB-1:0]};
   assign frac_y = ry_neg ? {1'b0, cfg.pos_y[FB-1:0]}
                          : FXB'(1 << FB) - {1'b0, cfg.pos_y[FB-1:0]};

   // Side distance start, split into two partial products per axis
   always_comb begin
      mul_a = ((state_ff == S_SD0) || (state_ff == S_SD1)) ? frac_x : frac_y;
      unique case (state_ff)
         S_SD0:   mul_b = {1'b0, dx_ff[FB-1:0]};
         S_SD1:   mul_b = dx_ff[2*FB:FB];
         S_SD2:   mul_b = {1'b0, dy_ff[FB-1:0]};
         default: mul_b = dy_ff[2*FB:FB];
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Camera plane times camera offset
   assign cam_plane = (state_ff == S_MULX) ? cfg.plane_x : cfg.plane_y;
   assign cam_p     = $signed(cam_plane) * cam_ff;

   // DDA step choice and next cell
   always_comb begin
      if (rx_ff == '0) step_x = 1'b0;
      else if (ry_ff == '0) step_x = 1'b1;
      else step_x = (sdx_ff < sdy_ff);
      nx = step_x ? (mx_ff + (rx_neg ? {CB{1'b1}} : CB'(1))) : mx_ff;
      ny = step_x ? my_ff : (my_ff + (ry_neg ? {CB{1'b1}} : CB'(1)));
      oob_next = (nx[CB-1:MB] != '0) | (ny[CB-1:MB] != '0);
      rd_addr  = {nx[MB-1:0], ny[MB-1:0]};
   end

   // Perpendicular distance numerator on the crossed axis
   always_comb begin
      coord   = side_ff ? my_ff : mx_ff;
      adj     = side_ff ? ry_neg : rx_neg;
      pos_w   = side_ff ? cfg.pos_y : cfg.pos_x;
      ray_w   = side_ff ? ry_ff : rx_ff;
      ray_abs = side_ff ? ry_abs : rx_abs;
      bsum    = {coord[CB-1], coord} + {{CB{1'b0}}, adj};
      num_w   = {bsum[CB], bsum, {FB{1'b0}}} - {4'b0, pos_w};
      num_abs = num_w[25] ? 25'(-num_w) : num_w[24:0];
      perp_zero = (num_w == '0) | (num_w[25] ^ ray_w[RB-1]);
   end

   // Draw rows and clamped hit cell
   always_comb begin
      half   = lh_ff[LB-1:1];
      de_sum = LB'(gdrc_pkg::HalfHeight) + {1'b0, half};
      hit_x_w = mx_ff[CB-1] ? '0 : (mx_ff[MB] ? {MB{1'b1}} : mx_ff[MB-1:0]);
      hit_y_w = my_ff[CB-1] ? '0 : (my_ff[MB] ? {MB{1'b1}} : my_ff[MB-1:0]);
   end

   // Map write port: clearing pass or write request
   always_comb begin
      mem_we    = (state_ff == S_CLEAR) | ((state_ff == S_IDLE) & head.valid & ~head.cast);
      mem_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : {head.req.cell_x, head.req.cell_y};
      mem_wdata = (state_ff == S_CLEAR) ? '0 : head.req.cell_code;
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= map_mem[rd_addr];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == {AB{1'b1}}) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (head.valid && head.cast) begin
                  column_ff <= head.req.column;
                  state_ff  <= S_CAM;
               end
            end
            S_CAM: begin
               cam_ff   <= $signed({1'b0, cam_prod[gdrc_pkg::CamShift +: gdrc_pkg::CamBits-1]})
                           - $signed(gdrc_pkg::CamBits'(1 << FB));
               mx_ff    <= CB'(cfg.pos_x[gdrc_pkg::PosBits-1:FB]);
               my_ff    <= CB'(cfg.pos_y[gdrc_pkg::PosBits-1:FB]);
               side_ff  <= 1'b1;
               iter_ff  <= '0;
               state_ff <= S_MULX;
            end
            S_MULX: begin
               cprod_ff <= cam_p;
               state_ff <= S_ADDX;
            end
            S_ADDX: begin
               rx_ff    <= cprod_ff[PRB-1:FB] + RB'($signed(cfg.dir_x));
               cprod_ff <= cam_p;
               state_ff <= S_ADDY;
            end
            S_ADDY: begin
               ry_ff    <= cprod_ff[PRB-1:FB] + RB'($signed(cfg.dir_y));
               state_ff <= S_DX;
            end
            S_DX: begin
               if (rx_ff == '0) begin
                  dx_ff    <= '0;
                  state_ff <= S_DY;
               end else begin
                  div_start_ff <= 1'b1;
                  div_num_ff   <= gdrc_pkg::DeltaNum;
                  div_den_ff   <= DB'(rx_abs);
                  state_ff     <= S_DX_W;
               end
            end
            S_DX_W: begin
               if (div_done) begin
                  dx_ff    <= div_quot[gdrc_pkg::DeltaBits-1:0];
                  state_ff <= S_DY;
               end
            end
            S_DY: begin
               if (ry_ff == '0) begin
                  dy_ff    <= '0;
                  state_ff <= S_SD0;
               end else begin
                  div_start_ff <= 1'b1;
                  div_num_ff   <= gdrc_pkg::DeltaNum;
                  div_den_ff   <= DB'(ry_abs);
                  state_ff     <= S_DY_W;
               end
            end
            S_DY_W: begin
               if (div_done) begin
                  dy_ff    <= div_quot[gdrc_pkg::DeltaBits-1:0];
                  state_ff <= S_SD0;
               end
            end
            S_SD0: begin
               sprod_ff <= mul_p;
               state_ff <= S_SD1;
            end
            S_SD1: begin
               sdx_ff   <= SB'(sprod_ff[SPB-1:FB]);
               sprod_ff <= mul_p;
               state_ff <= S_SD2;
            end
            S_SD2: begin
               sdx_ff   <= sdx_ff + SB'(sprod_ff);
               sprod_ff <= mul_p;
               state_ff <= S_SD3;
            end
            S_SD3: begin
               sdy_ff   <= SB'(sprod_ff[SPB-1:FB]);
               sprod_ff <= mul_p;
               state_ff <= S_SD4;
            end
            S_SD4: begin
               sdy_ff   <= sdy_ff + SB'(sprod_ff);
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (step_x) begin
                  sdx_ff  <= sdx_ff + SB'(dx_ff);
                  side_ff <= 1'b0;
               end else begin
                  sdy_ff  <= sdy_ff + SB'(dy_ff);
                  side_ff <= 1'b1;
               end
               mx_ff    <= nx;
               my_ff    <= ny;
               oob_ff   <= oob_next;
               iter_ff  <= iter_ff + 1'b1;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               priority if (oob_ff) begin
                  escaped_ff <= 1'b1;
                  code_ff    <= '0;
                  state_ff   <= S_PERP;
               end else if (mem_q_ff != '0) begin
                  escaped_ff <= 1'b0;
                  code_ff    <= mem_q_ff;
                  state_ff   <= S_PERP;
               end else if (iter_ff == gdrc_pkg::IterBits'(gdrc_pkg::WalkLimit)) begin
                  escaped_ff <= 1'b1;
                  code_ff    <= '0;
                  state_ff   <= S_PERP;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_PERP: begin
               priority if (ray_w == '0) begin
                  perp_ff  <= gdrc_pkg::PerpMax;
                  state_ff <= S_LH;
               end else if (perp_zero) begin
                  perp_ff  <= '0;
                  state_ff <= S_LH;
               end else begin
                  div_start_ff <= 1'b1;
                  div_num_ff   <= NB'({num_abs, {FB{1'b0}}});
                  div_den_ff   <= DB'(ray_abs);
                  state_ff     <= S_PERP_W;
               end
            end
            S_PERP_W: begin
               if (div_done) begin
                  perp_ff  <= (div_quot > NB'(gdrc_pkg::PerpMax)) ? gdrc_pkg::PerpMax
                                                                   : div_quot[PB-1:0];
                  state_ff <= S_LH;
               end
            end
            S_LH: begin
               if (perp_ff == '0) begin
                  lh_ff    <= gdrc_pkg::LineMax;
                  state_ff <= S_OUT;
               end else begin
                  div_start_ff <= 1'b1;
                  div_num_ff   <= gdrc_pkg::LineNum;
                  div_den_ff   <= perp_ff;
                  state_ff     <= S_LH_W;
               end
            end
            S_LH_W: begin
               if (div_done) begin
                  lh_ff    <= (div_quot > NB'(gdrc_pkg::LineMax)) ? gdrc_pkg::LineMax
                                                                  : div_quot[LB-1:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               rsp_valid_ff         <= 1'b1;
               rsp_ff.out_column    <= column_ff;
               rsp_ff.hit_x         <= hit_x_w;
               rsp_ff.hit_y         <= hit_y_w;
               rsp_ff.wall_code     <= code_ff;
               rsp_ff.hit_side      <= side_ff;
               rsp_ff.escaped       <= escaped_ff;
               rsp_ff.perp_distance <= perp_ff;
               rsp_ff.line_height   <= lh_ff;
               rsp_ff.draw_start    <= ({1'b0, half} > LB'(gdrc_pkg::HalfHeight)) ? '0
                                       : WB'(LB'(gdrc_pkg::HalfHeight) - {1'b0, half});
               rsp_ff.draw_end      <= (de_sum > LB'(gdrc_pkg::LastRow)) ? gdrc_pkg::LastRow
                                       : de_sum[WB-1:0];
               state_ff             <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/grid_dda_ray_caster.sv
// Top level of the grid DDA ray caster: ports, camera registers, front and back.
//
// After reset the 64x64 map is swept to zero, one cell a cycle, with busy high. A request
// is taken when start is high and busy is low; a two-entry queue sits between intake and
// execution, so busy drops again as soon as a slot is free. A map write is done in the
// back end's idle state and gives no result. A cast forms its camera offset with a
// reciprocal multiply, then runs up to four divisions (two ray deltas, perpendicular
// distance, line height) on one shared divider at 2 bits a cycle; each cell the DDA walk
// visits takes a step state and a check state (map read is registered). The result shows
// on the rsp_ ports for exactly one cycle with rsp_valid high and cannot be held off.
module grid_dda_ray_caster (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [7:0]  req_cell_code,
   input  logic [9:0]  req_column,
   output logic        rsp_valid,
   output logic [9:0]  rsp_out_column,
   output logic [5:0]  rsp_hit_x,
   output logic [5:0]  rsp_hit_y,
   output logic [7:0]  rsp_wall_code,
   output logic        rsp_hit_side,
   output logic        rsp_escaped,
   output logic [23:0] rsp_perp_distance,
   output logic [11:0] rsp_line_height,
   output logic [8:0]  rsp_draw_start,
   output logic [8:0]  rsp_draw_end,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata
);

   gdrc_pkg::cfg_type      cfg_ff;
   gdrc_pkg::req_type      req_in;
   gdrc_pkg::head_type     head;
   gdrc_pkg::back_ctl_type back_ctl;
   gdrc_pkg::rsp_type      rsp;

   // Camera registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x   <= 22'd131072;
         cfg_ff.pos_y   <= 22'd131072;
         cfg_ff.dir_x   <= 18'h30000;
         cfg_ff.dir_y   <= 18'd0;
         cfg_ff.plane_x <= 18'd0;
         cfg_ff.plane_y <= 18'd43253;
      end else if (csr_we) begin
         if (csr_index == gdrc_pkg::CsrPosX)   cfg_ff.pos_x   <= csr_wdata;
         if (csr_index == gdrc_pkg::CsrPosY)   cfg_ff.pos_y   <= csr_wdata;
         if (csr_index == gdrc_pkg::CsrDirX)   cfg_ff.dir_x   <= csr_wdata[17:0];
         if (csr_index == gdrc_pkg::CsrDirY)   cfg_ff.dir_y   <= csr_wdata[17:0];
         if (csr_index == gdrc_pkg::CsrPlaneX) cfg_ff.plane_x <= csr_wdata[17:0];
         if (csr_index == gdrc_pkg::CsrPlaneY) cfg_ff.plane_y <= csr_wdata[17:0];
      end
   end

   // Request bundle
   assign req_in.action    = req_action;
   assign req_in.cell_x    = req_cell_x;
   assign req_in.cell_y    = req_cell_y;
   assign req_in.cell_code = req_cell_code;
   assign req_in.column    = req_column;

   gdrc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_in   (req_in),
      .back_ctl (back_ctl),
      .busy     (busy),
      .head     (head)
   );

   gdrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .back_ctl  (back_ctl),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // Result ports
   assign rsp_out_column    = rsp.out_column;
   assign rsp_hit_x         = rsp.hit_x;
   assign rsp_hit_y         = rsp.hit_y;
   assign rsp_wall_code     = rsp.wall_code;
   assign rsp_hit_side      = rsp.hit_side;
   assign rsp_escaped       = rsp.escaped;
   assign rsp_perp_distance = rsp.perp_distance;
   assign rsp_line_height   = rsp.line_height;
   assign rsp_draw_start    = rsp.draw_start;
   assign rsp_draw_end      = rsp.draw_end;

   // Checks
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      back_ctl.clearing |-> busy)
      else $error("request accepted during map clear");

   a_rows_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_draw_start <= rsp_draw_end))
      else $error("draw start after draw end");

   a_escape_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_escaped) |-> (rsp_wall_code == 8'd0))
      else $error("escaped ray with nonzero wall code");

endmodule

>>> tb/gdrc_checker.sv
// Checker for the grid DDA ray caster: tracks map and camera, predicts casts, compares.
module gdrc_checker
   import gdrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_action,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [7:0]  req_cell_code,
   input  logic [9:0]  req_column,
   input  logic        rsp_valid,
   input  logic [9:0]  rsp_out_column,
   input  logic [5:0]  rsp_hit_x,
   input  logic [5:0]  rsp_hit_y,
   input  logic [7:0]  rsp_wall_code,
   input  logic        rsp_hit_side,
   input  logic        rsp_escaped,
   input  logic [23:0] rsp_perp_distance,
   input  logic [11:0] rsp_line_height,
   input  logic [8:0]  rsp_draw_start,
   input  logic [8:0]  rsp_draw_end,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata,
   output int          errors,
   output int          pending
);

   localparam longint One = 64'd1 << FracBits;

   logic [CodeBits-1:0] cells [MapCells];
   cfg_type             cam_cfg;
   rsp_type             casts_due [$];

   // Model of one cast against the tracked map and camera
   function automatic rsp_type trace_ray(logic [ColBits-1:0] col);
      longint  cam, rx, ry, mx, my, sx, sy, num, ray, perp, lh, ds, de;
      longint  dx, dy, sdx, sdy, frac;
      int      side, esc, code, hit;
      bit      go_x;
      rsp_type r;
      dx = 0; dy = 0; side = 1; esc = 0; code = 0; hit = 0;
      cam = (2 * longint'(col) * One) / ScreenWidth - One;
      rx = longint'($signed(cam_cfg.dir_x)) + ((longint'($signed(cam_cfg.plane_x)) * cam) >>> 16);
      ry = longint'($signed(cam_cfg.dir_y)) + ((longint'($signed(cam_cfg.plane_y)) * cam) >>> 16);
      mx = longint'(cam_cfg.pos_x) >> FracBits;
      my = longint'(cam_cfg.pos_y) >> FracBits;
      if (rx != 0) dx = (One * One) / (rx < 0 ? -rx : rx);
      if (ry != 0) dy = (One * One) / (ry < 0 ? -ry : ry);
      // distance to first border, scaled by delta
      if (rx < 0) begin
         sx = -1; frac = longint'(cam_cfg.pos_x) & (One - 1);
      end else begin
         sx = 1;  frac = One - (longint'(cam_cfg.pos_x) & (One - 1));
      end
      sdx = (dx >> FracBits) * frac + (((dx & (One - 1)) * frac) >> FracBits);
      if (ry < 0) begin
         sy = -1; frac = longint'(cam_cfg.pos_y) & (One - 1);
      end else begin
         sy = 1;  frac = One - (longint'(cam_cfg.pos_y) & (One - 1));
      end
      sdy = (dy >> FracBits) * frac + (((dy & (One - 1)) * frac) >> FracBits);
      // grid walk; x only on strictly smaller side distance
      for (int i = 0; i < WalkLimit && hit == 0; i++) begin
         if (rx == 0) go_x = 0;
         else if (ry == 0) go_x = 1;
         else go_x = sdx < sdy;
         if (go_x) begin
            sdx += dx; mx += sx; side = 0;
         end else begin
            sdy += dy; my += sy; side = 1;
         end
         if (mx < 0 || mx >= 64 || my < 0 || my >= 64) begin
            esc = 1; hit = 1;
         end else if (cells[mx * 64 + my] != 0) begin
            code = cells[mx * 64 + my]; hit = 1;
         end
      end
      if (hit == 0) begin
         esc = 1; code = 0;
      end
      if (side == 0) begin
         num = (mx + (sx < 0 ? 1 : 0)) * One - longint'(cam_cfg.pos_x); ray = rx;
      end else begin
         num = (my + (sy < 0 ? 1 : 0)) * One - longint'(cam_cfg.pos_y); ray = ry;
      end
      if (ray == 0) perp = longint'(PerpMax);
      else begin
         perp = (num * One) / ray;
         if (perp < 0) perp = 0;
         if (perp > longint'(PerpMax)) perp = longint'(PerpMax);
      end
      if (perp == 0) lh = longint'(LineMax);
      else begin
         lh = (longint'(ScreenHeight) * One) / perp;
         if (lh > longint'(LineMax)) lh = longint'(LineMax);
      end
      ds = ScreenHeight / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = ScreenHeight / 2 + lh / 2;
      if (de >= ScreenHeight) de = ScreenHeight - 1;
      r.out_column    = col;
      r.hit_x         = MapBits'(mx < 0 ? 0 : (mx > 63 ? 63 : mx));
      r.hit_y         = MapBits'(my < 0 ? 0 : (my > 63 ? 63 : my));
      r.wall_code     = CodeBits'(code);
      r.hit_side      = side[0];
      r.escaped       = esc[0];
      r.perp_distance = PerpBits'(perp);
      r.line_height   = LineBits'(lh);
      r.draw_start    = RowBits'(ds);
      r.draw_end      = RowBits'(de);
      return r;
   endfunction

   function automatic int field_bad(string name, longint want, longint got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
   endfunction

   assign pending = casts_due.size();

   // Track requests, register writes and results
   always @(posedge clock) begin
      rsp_type w;
      int      bad;
      if (reset) begin
         foreach (cells[k]) cells[k] = '0;
         cam_cfg.pos_x   = 22'd131072;
         cam_cfg.pos_y   = 22'd131072;
         cam_cfg.dir_x   = 18'h30000;
         cam_cfg.dir_y   = '0;
         cam_cfg.plane_x = '0;
         cam_cfg.plane_y = 18'd43253;
         casts_due.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrPosX:   cam_cfg.pos_x   = csr_wdata;
               CsrPosY:   cam_cfg.pos_y   = csr_wdata;
               CsrDirX:   cam_cfg.dir_x   = csr_wdata[VecBits-1:0];
               CsrDirY:   cam_cfg.dir_y   = csr_wdata[VecBits-1:0];
               CsrPlaneX: cam_cfg.plane_x = csr_wdata[VecBits-1:0];
               CsrPlaneY: cam_cfg.plane_y = csr_wdata[VecBits-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_action == ActCast) casts_due.push_back(trace_ray(req_column));
            else cells[{req_cell_x, req_cell_y}] = req_cell_code;
         end
         if (rsp_valid) begin
            if (casts_due.size() == 0) begin
               $display("%0t: unexpected result for column %0d", $time, rsp_out_column);
               errors++;
            end else begin
               w = casts_due.pop_front();
               bad = field_bad("out_column", w.out_column, rsp_out_column)
                   + field_bad("hit_x", w.hit_x, rsp_hit_x)
                   + field_bad("hit_y", w.hit_y, rsp_hit_y)
                   + field_bad("wall_code", w.wall_code, rsp_wall_code)
                   + field_bad("hit_side", w.hit_side, rsp_hit_side)
                   + field_bad("escaped", w.escaped, rsp_escaped)
                   + field_bad("perp_distance", w.perp_distance, rsp_perp_distance)
                   + field_bad("line_height", w.line_height, rsp_line_height)
                   + field_bad("draw_start", w.draw_start, rsp_draw_start)
                   + field_bad("draw_end", w.draw_end, rsp_draw_end);
               if (bad != 0) errors++;
            end
         end
      end
   end

endmodule

>>> tb/tb.sv
// Testbench top for the grid DDA ray caster: clock, reset, stimulus and verdict.
module tb;
   import gdrc_pkg::*;

   localparam logic [CsrBits-1:0] CsrSpareA = 3'd6;
   localparam logic [CsrBits-1:0] CsrSpareB = 3'd7;
   localparam int CycleLimit = 3000000;
   localparam int RandItems  = 1200;

   logic        clock, reset, start, busy;
   logic        req_action;
   logic [5:0]  req_cell_x, req_cell_y;
   logic [7:0]  req_cell_code;
   logic [9:0]  req_column;
   logic        rsp_valid;
   logic [9:0]  rsp_out_column;
   logic [5:0]  rsp_hit_x, rsp_hit_y;
   logic [7:0]  rsp_wall_code;
   logic        rsp_hit_side, rsp_escaped;
   logic [23:0] rsp_perp_distance;
   logic [11:0] rsp_line_height;
   logic [8:0]  rsp_draw_start, rsp_draw_end;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [21:0] csr_wdata;
   int          errors, pending, cycles;
   int          burst_left, sent, gap_max;

   grid_dda_ray_caster u_dut (.*);

   gdrc_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One request, held until the block takes it; start stays high afterwards unless a random gap follows
   task automatic push_req(logic act, logic [5:0] cx, logic [5:0] cy,
                           logic [7:0] code, logic [9:0] col);
      start         <= 1'b1;
      req_action    <= act;
      req_cell_x    <= cx;
      req_cell_y    <= cy;
      req_cell_code <= code;
      req_column    <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      // bursts with random gaps
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         if (gap_max > 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   task automatic cast_col(logic [9:0] col);
      push_req(ActCast, $urandom, $urandom, $urandom, col);
   endtask

   task automatic put_cell(logic [5:0] cx, logic [5:0] cy, logic [7:0] code);
      push_req(ActWrite, cx, cy, code, $urandom);
   endtask

   // Let everything finish, then let trailing map writes settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [21:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [21:0] pick_vec();
      case ($urandom_range(0, 7))
         0: return 22'(18'h20000);
         1: return 22'(18'h1FFFF);
         2: return 22'd0;
         3: return 22'($urandom_range(0, 262143));
         default: return 22'($urandom_range(0, 131071)) - 22'd65536 & 22'h3FFFF
                       | {$urandom_range(0, 15), 18'd0};
      endcase
   endfunction

   function automatic logic [21:0] pick_pos();
      logic [21:0] p;
      case ($urandom_range(0, 9))
         0: p = 22'h3FFFFF;
         1: p = 22'd0;
         default: p = {6'($urandom_range(1, 62)), 16'($urandom)};
      endcase
      if ($urandom_range(0, 3) == 0) p[15:0] = '0;
      return p;
   endfunction

   task automatic new_camera();
      csr_write(CsrPosX, pick_pos());
      csr_write(CsrPosY, pick_pos());
      csr_write(CsrDirX, pick_vec());
      csr_write(CsrDirY, pick_vec());
      csr_write(CsrPlaneX, pick_vec());
      csr_write(CsrPlaneY, pick_vec());
      csr_write($urandom_range(0, 1) ? CsrSpareA : CsrSpareB, $urandom);
   endtask

   initial begin
      int density;
      cycles = 0; burst_left = 0; sent = 0; gap_max = 0;
      reset = 1; start = 0; csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_action = 0; req_cell_x = '0; req_cell_y = '0; req_cell_code = '0;
      req_column = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed: reset camera into an empty map, then corners and screen edges
      cast_col(10'd0);
      cast_col(10'd639);
      cast_col(10'd320);
      cast_col(10'd1023);
      put_cell(6'd0, 6'd0, 8'd255);
      put_cell(6'd63, 6'd63, 8'd1);
      put_cell(6'd0, 6'd2, 8'd7);
      put_cell(6'd0, 6'd2, 8'd0);
      put_cell(6'd0, 6'd1, 8'hAA);
      put_cell(6'd0, 6'd3, 8'h55);
      cast_col(10'd0);
      cast_col(10'd639);
      cast_col(10'd320);
      drain();
      // both ray components zero, extreme position and vectors, then perpendicular to a wall on a cell border
      csr_write(CsrDirX, '0);
      csr_write(CsrPlaneY, '0);
      cast_col(10'd100);
      drain();
      csr_write(CsrPosX, 22'h3FFFFF);
      csr_write(CsrPosY, 22'd0);
      csr_write(CsrDirX, 22'(18'h1FFFF));
      csr_write(CsrDirY, 22'(18'h20000));
      csr_write(CsrPlaneX, 22'(18'h20000));
      csr_write(CsrPlaneY, 22'(18'h1FFFF));
      csr_write(CsrSpareB, 22'h3FFFFF);
      cast_col(10'd0);
      cast_col(10'd639);
      drain();
      csr_write(CsrPosX, 22'h20000);
      csr_write(CsrPosY, 22'h18000);
      csr_write(CsrDirX, 22'(18'h30000));
      csr_write(CsrDirY, '0);
      csr_write(CsrPlaneX, '0);
      cast_col(10'd320);
      cast_col(10'd319);
      drain();

      // Random phases: new camera, scatter walls, then casts with a few map edits
      while (sent < RandItems) begin
         new_camera();
         gap_max = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
         density = $urandom_range(5, 60);
         repeat (density) begin
            put_cell($urandom, $urandom, $urandom_range(0, 5) == 0 ? 8'd0 : 8'($urandom));
            sent++;
         end
         repeat ($urandom_range(40, 120)) begin
            if ($urandom_range(0, 5) == 0)
               put_cell($urandom, $urandom, $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom));
            else if ($urandom_range(0, 9) == 0)
               cast_col($urandom_range(0, 1023));
            else
               cast_col($urandom_range(0, 639));
            sent++;
         end
         drain();
      end

      repeat (400) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
src/gdrc_pkg.sv
src/gdrc_front.sv
src/gdrc_div.sv
src/gdrc_back.sv
src/grid_dda_ray_caster.sv
tb/gdrc_checker.sv
tb/tb.sv
